// ----- rtl/sha_pkg.sv -----
// sha_pkg: shared types, constants and round functions for the sha-256 stream hasher
// used by sha_front, sha_fifo, sha_back and sha256_stream_hasher_core
// no dependencies
package sha_pkg;

    localparam int CMD_FIFO_DEPTH = 4;

    // kind of work the back end does for one queued command
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_END,
        CMD_BYTE_END
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- rtl/sha_front.sv -----
// sha_front: accepts input transfers, classifies them into queue commands
// items that carry neither a byte nor an end are dropped here; depends on sha_pkg
module sha_front
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    output logic       o_tready,
    input  logic [7:0] i_tdata,
    input  logic       i_tuser,
    input  logic       i_tlast,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;
    logic keep;

    assign o_tready    = !r_valid || i_cmd_ready;
    assign take        = i_tvalid && o_tready;
    assign keep        = take && (i_tuser || i_tlast);
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.data = i_tdata;
        if (i_tuser && i_tlast) begin
            n_cmd.kind = CMD_BYTE_END;
        end else if (i_tuser) begin
            n_cmd.kind = CMD_BYTE;
        end else begin
            n_cmd.kind = CMD_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (keep) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- rtl/sha_fifo.sv -----
// sha_fifo: short command queue between the front and back of the hasher
// depends on sha_pkg for the command type
module sha_fifo
    import sha_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/sha_back.sv -----
// sha_back: block assembly, padding, 64-round compression and digest output
// depends on sha_pkg for commands, constants and round functions
module sha_back
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_word,
    output logic [2:0]  o_out_index,
    output logic        o_out_last
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PAD,
        S_COMP,
        S_FIN,
        S_OUT
    } t_state;

    t_state       r_state;
    t_state       r_ret;
    logic [5:0]   r_fill;
    logic [60:0]  r_cnt;
    logic [23:0]  r_acc;
    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [31:0]  r_h [8];
    logic [5:0]   r_round;
    logic         r_pad_first;
    logic         r_len_ok;
    logic         r_ovalid;
    logic [2:0]   r_oidx;

    logic         pop;
    logic         cmd_byte;
    logic         cmd_end;
    logic         app_en;
    logic [7:0]   app_byte;
    logic [7:0]   pad_byte;
    logic [63:0]  len_bits;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  n_w;
    logic [31:0]  n_v [8];

    assign o_cmd_ready = (r_state == S_LOAD);
    assign pop         = o_cmd_ready && i_cmd_valid;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_h[0];
    assign o_out_index = r_oidx;
    assign o_out_last  = (r_oidx == 3'd7);
    assign len_bits    = {r_cnt, 3'b000};

    always_comb begin
        case (i_cmd.kind)
            CMD_BYTE: begin
                cmd_byte = 1'b1;
                cmd_end  = 1'b0;
            end
            CMD_BYTE_END: begin
                cmd_byte = 1'b1;
                cmd_end  = 1'b1;
            end
            CMD_END: begin
                cmd_byte = 1'b0;
                cmd_end  = 1'b1;
            end
            default: begin
                cmd_byte = 1'b0;
                cmd_end  = 1'b0;
            end
        endcase
    end

    // pad sequence: marker byte, zeros, then the bit length big-endian in bytes 56..63
    always_comb begin
        if (r_pad_first) begin
            pad_byte = PAD_MARK;
        end else if (r_len_ok && r_fill[5:3] == 3'd7) begin
            pad_byte = len_bits[(3'd7 - r_fill[2:0]) * 8 +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign app_en   = (pop && cmd_byte) || (r_state == S_PAD);
    assign app_byte = (r_state == S_PAD) ? pad_byte : i_cmd.data;

    // one round of the compression and the next schedule word
    always_comb begin
        t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + ROUND_K[r_round] + r_w[0];
        t2 = big_sigma0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        n_v[0] = t1 + t2;
        n_v[1] = r_v[0];
        n_v[2] = r_v[1];
        n_v[3] = r_v[2];
        n_v[4] = r_v[3] + t1;
        n_v[5] = r_v[4];
        n_v[6] = r_v[5];
        n_v[7] = r_v[6];
        n_w = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ret       <= S_LOAD;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_round     <= '0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_ovalid    <= 1'b0;
            r_oidx      <= '0;
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= HASH_IV[j];
            end
        end else begin
            if (app_en) begin
                r_acc  <= {r_acc[15:0], app_byte};
                r_fill <= r_fill + 6'd1;
                if (r_fill[1:0] == 2'd3) begin
                    for (int j = 0; j < 15; j++) begin
                        r_w[j] <= r_w[j+1];
                    end
                    r_w[15] <= {r_acc, app_byte};
                end
            end
            case (r_state)
                S_LOAD: begin
                    if (pop) begin
                        if (cmd_byte) begin
                            r_cnt <= r_cnt + 61'd1;
                        end
                        if (cmd_end) begin
                            r_pad_first <= 1'b1;
                        end
                        if (cmd_byte && r_fill == 6'd63) begin
                            r_state <= S_COMP;
                            r_round <= '0;
                            r_v     <= r_h;
                            r_ret   <= cmd_end ? S_PAD : S_LOAD;
                        end else if (cmd_end) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (r_pad_first) begin
                        r_pad_first <= 1'b0;
                    end
                    if (r_fill == 6'd63) begin
                        r_state <= S_COMP;
                        r_round <= '0;
                        r_v     <= r_h;
                        if (r_len_ok && !r_pad_first) begin
                            r_ret <= S_OUT;
                        end else begin
                            // block ended before the length fit: one more block follows
                            r_ret    <= S_PAD;
                            r_len_ok <= 1'b1;
                        end
                    end else if (r_pad_first) begin
                        r_len_ok <= (r_fill < 6'd56);
                    end
                end
                S_COMP: begin
                    r_v <= n_v;
                    for (int j = 0; j < 15; j++) begin
                        r_w[j] <= r_w[j+1];
                    end
                    r_w[15] <= n_w;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                    r_state <= r_ret;
                    if (r_ret == S_OUT) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= '0;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int j = 0; j < 8; j++) begin
                                r_h[j] <= HASH_IV[j];
                            end
                            r_cnt    <= '0;
                            r_len_ok <= 1'b0;
                            r_ovalid <= 1'b0;
                            r_state  <= S_LOAD;
                        end else begin
                            for (int j = 0; j < 7; j++) begin
                                r_h[j] <= r_h[j+1];
                            end
                            r_h[7] <= r_h[0];
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// ----- rtl/sha256_stream_hasher_core.sv -----
// sha256 stream hasher: one message byte per transfer in, eight digest words out
// an item waits in the front register until the queue has room; the back end takes one byte
// a cycle while loading and stalls for each full block (64 rounds plus the final add)
// at end of message: pad bytes, one or two compressions, then 8 output transfers
// on long messages the single round unit sets the pace: no bytes are taken while a block compresses
// reset: i_rst_n synchronous active low, clears control state and loads the initial hash
module sha256_stream_hasher_core
    import sha_pkg::*;
#(
    parameter int FIFO_DEPTH = CMD_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] byte_valid
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast
);

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic queue_valid;
    logic queue_ready;
    t_cmd queue_cmd;

    sha_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .i_tlast     (i_s_axis_tlast),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    sha_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_cmd    (queue_cmd)
    );

    sha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_word  (o_m_axis_tdata),
        .o_out_index (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

// ----- tb/sv/sha256_digest_checker.sv -----
`timescale 1ns / 1ps
// sha256_digest_checker: watches both stream channels of the hasher, predicts the digest
// of every message from the accepted bytes and compares each output word in order
// no dependencies beyond the port signals of sha256_stream_hasher_core
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] digest_word
    input  logic [2:0]  i_m_tuser,   // [2:0] word_index
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_messages,
    output int          o_words_checked
);

    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_entry;

    t_digest_entry expected_words [$];

    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] msg_bit_len;

    int fail_total;
    int pending_words;
    int message_total;
    int words_total;

    assign o_fail_count    = fail_total;
    assign o_pending       = pending_words;
    assign o_messages      = message_total;
    assign o_words_checked = words_total;

    initial begin
        fail_total    = 0;
        pending_words = 0;
        message_total = 0;
        words_total   = 0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of msg_block into hash_state
    function automatic void crunch_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e;
            e = d + t1;
            d = c; c = b; b = a;
            a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void clear_message();
        for (int j = 0; j < 8; j++) hash_state[j] = START_HASH[j];
        block_fill  = 0;
        msg_bit_len = '0;
    endfunction

    // fold one accepted input transfer into the running hash
    function automatic void absorb_item(input logic [7:0] data, input logic valid,
                                        input logic last);
        t_digest_entry ent;
        if (valid) begin
            msg_block[block_fill] = data;
            block_fill++;
            msg_bit_len += 64'd8;
            if (block_fill == 64) begin
                crunch_block();
                block_fill = 0;
            end
        end
        if (last) begin
            msg_block[block_fill] = PAD_BYTE;
            block_fill++;
            // no room for the length field: pad out and compress an extra block
            if (block_fill > 56) begin
                while (block_fill < 64) begin
                    msg_block[block_fill] = 8'h00;
                    block_fill++;
                end
                crunch_block();
                block_fill = 0;
            end
            while (block_fill < 56) begin
                msg_block[block_fill] = 8'h00;
                block_fill++;
            end
            for (int j = 0; j < 8; j++) msg_block[56+j] = msg_bit_len[63-8*j -: 8];
            crunch_block();
            for (int j = 0; j < 8; j++) begin
                ent.word  = hash_state[j];
                ent.index = j[2:0];
                ent.last  = (j == 7);
                expected_words.insert(expected_words.size(), ent);
            end
            message_total++;
            clear_message();
        end
    endfunction

    function automatic void flag_mismatch(input string msg);
        fail_total++;
        if (fail_total <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic void check_word(input logic [31:0] word, input logic [2:0] index,
                                       input logic last);
        t_digest_entry ent;
        if (expected_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected digest word %h index %0d last %0b",
                                    word, index, last));
            return;
        end
        ent = expected_words.pop_front();
        words_total++;
        if (word !== ent.word || index !== ent.index || last !== ent.last) begin
            flag_mismatch($sformatf(
                "digest word mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                ent.word, ent.index, ent.last, word, index, last));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            expected_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_word(i_m_tdata, i_m_tuser, i_m_tlast);
            if (i_s_tvalid && i_s_tready) absorb_item(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        pending_words = expected_words.size();
    end

endmodule

// ----- tb/sv/tb_sha256_stream_hasher_core.sv -----
`timescale 1ns / 1ps
// tb_sha256_stream_hasher_core: byte stream stimulus with bursty input and stalling output
// for the sha-256 stream hasher; checking is done by sha256_digest_checker
// depends on sha_pkg, sha256_stream_hasher_core and sha256_digest_checker
module tb_sha256_stream_hasher_core;

    localparam int HOLD_CYCLES = 500;
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 300;
    localparam int ITEM_TARGET = 230;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count, pending, messages, words_checked;

    // sender bookkeeping
    int items_sent  = 0;
    int burst_left  = 1;
    bit offering    = 0;
    bit rand_phase  = 0;
    bit hold_done   = 0;
    int longest_msg = 0;

    sha256_stream_hasher_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    sha256_digest_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_messages      (messages),
        .o_words_checked (words_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // offer one item and return at the edge where it transfers, or after an idle gap that follows it
    task automatic push_item(input logic [7:0] data, input logic valid, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= last;
        offering = 1;
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 100);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                offering = 0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering and wait until every predicted digest word has come out
    task automatic drain_wait();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 0;
        end
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_message(input int len);
        bit end_with_byte;
        end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        if (len > longest_msg) longest_msg = len;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (i == len - 1));
        end
        if (!end_with_byte) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin
        int msg_idx;
        int len;
        msg_idx = 0;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message
        push_item(8'h00, 1'b0, 1'b1);
        // one zero byte together with the end marker
        push_item(8'h00, 1'b1, 1'b1);
        // one byte, then an end with no byte
        push_item(8'hff, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // "abc" with an ignored filler transfer in the middle
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        // bit pattern edges
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h7f, 1'b1, 1'b0);
        push_item(8'h01, 1'b1, 1'b0);
        push_item(8'hfe, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b1);
        drain_wait();

        rand_phase = 1;
        // length field just fits, spills into an extra block, exactly one block
        send_message(55);
        send_message(56);
        send_message(64);
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 5))
                    0: len = 57;
                    1: len = 63;
                    2: len = 65;
                    3: len = 119;
                    4: len = 120;
                    default: len = 128;
                endcase
            end else begin
                len = $urandom_range(0, 12);
            end
            // keep the total close to the item budget
            if (items_sent + len + len / 8 + 2 > ITEM_TARGET + 10) begin
                len = $urandom_range(0, 12);
            end
            send_message(len);
            msg_idx++;
            if (msg_idx == 12) drain_wait();
        end

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d messages (longest %0d bytes), %0d input transfers, %0d words",
                 messages, longest_msg, items_sent, words_checked);
        $display("mismatches: %0d, words still expected: %0d", fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("[sha256_stream_hasher_core] OK");
        end else begin
            $display("[sha256_stream_hasher_core] ERROR");
        end
        $finish;
    end

    // output side stalls in segments of varying pattern, once for a long stretch
    initial begin
        int mode;
        int seg;
        int period;
        int cyc;
        cyc = 0;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (rand_phase && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1;
            end
            mode   = $urandom_range(0, 4);
            seg    = $urandom_range(16, 128);
            period = $urandom_range(2, 8);
            repeat (seg) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    3: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (cyc % period == 0);
                endcase
                cyc++;
                @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("[sha256_stream_hasher_core] ERROR");
                $finish;
            end
        end
    end

endmodule
